// File: rtl/wksq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wksq_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned ACC_W   = 4;
  localparam int unsigned HIST_W  = 8;

  localparam logic [IDX_W-1:0] REG_VOL_UP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MUTE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_VOL_DOWN = 3'd2;
  localparam logic [IDX_W-1:0] REG_FORWARD  = 3'd3;
  localparam logic [IDX_W-1:0] REG_REVERSE  = 3'd4;

  localparam logic [CODE_W-1:0] RST_VOL_UP   = 8'h21;
  localparam logic [CODE_W-1:0] RST_MUTE     = 8'h71;
  localparam logic [CODE_W-1:0] RST_VOL_DOWN = 8'hA1;
  localparam logic [CODE_W-1:0] RST_FORWARD  = 8'hC9;
  localparam logic [CODE_W-1:0] RST_REVERSE  = 8'h49;
  localparam logic [CODE_W-1:0] CODE_NONE    = 8'h00;

  localparam logic [HIST_W-1:0] KEY_MASK  = 8'b1100_0111;
  localparam logic [HIST_W-1:0] KEY_MATCH = 8'b0000_0111;
  localparam logic [HIST_W-1:0] KEY_FULL  = 8'b1111_1111;

  localparam logic [ACC_W-1:0]  POS_NONE  = 4'hF;
  localparam logic [HIST_W-1:0] PHIST_RST = 8'hFF;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } wksq_state_t;

  typedef enum logic [1:0] {
    TURN_NONE,
    TURN_FWD,
    TURN_REV
  } wksq_turn_t;

  function automatic wksq_turn_t turn_decode(input logic [HIST_W-1:0] h);
    wksq_turn_t t;
    case (h)
      8'h02, 8'h10, 8'h21: t = TURN_FWD;
      8'h01, 8'h12, 8'h20: t = TURN_REV;
      default:             t = TURN_NONE;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wksq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wksq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      vol_up_level;
  logic                      mute_level;
  logic                      vol_down_level;
  logic [wksq_pkg::POS_W-1:0] wheel_position;

  modport source (output valid, vol_up_level, mute_level, vol_down_level, wheel_position,
                  input ready);
  modport sink   (input valid, vol_up_level, mute_level, vol_down_level, wheel_position,
                  output ready);
endinterface

interface wksq_out_if;
  logic                       valid;
  logic                       ready;
  logic [wksq_pkg::CODE_W-1:0] key_code;
  logic [wksq_pkg::CODE_W-1:0] turn_code;

  modport source (output valid, key_code, turn_code, input ready);
  modport sink   (input valid, key_code, turn_code, output ready);
endinterface

interface wksq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wksq_pkg::IDX_W-1:0]  index;
  logic [wksq_pkg::CODE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/wheel_and_key_scan_qualifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Key and wheel scan qualifier. Each input word is one scan tick: three raw key
// levels and a wheel sample. A key is reported when its 8-bit history matches
// 00xxx111 (vol-down wins over mute, mute over vol-up); the wheel sample passes
// three times through a WINDOW_DEPTH-cell shift chain, and a position is taken
// only when the sample and every cell but the last agree, a change being
// decoded into a forward or reverse step. The unit takes no new word until
// the last of the three passes is done, and that pass stalls while an
// earlier result waits; the result register frees the input side while a
// result waits. Config writes are taken in any cycle with cfg_ch.ready held high.
module wheel_and_key_scan_qualifier_unit #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  wksq_in_if.sink    in_ch,
  wksq_out_if.source out_ch,
  wksq_cfg_if.sink   cfg_ch
);
  import wksq_pkg::*;

  wksq_state_t state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;

  logic [CODE_W-1:0] vol_up_code_r, mute_code_r, vol_down_code_r;
  logic [CODE_W-1:0] forward_code_r, reverse_code_r;

  logic              up_r, mute_r, down_r;
  logic [POS_W-1:0]  pos_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [HIST_W-1:0] phist_r, phist_nxt;
  logic [CODE_W-1:0] key_w_r, key_w_nxt;
  logic [CODE_W-1:0] turn_w_r, turn_w_nxt;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_key_r, out_turn_r;

  logic in_fire, adv, step_en, key_en, finish, agree;
  logic hit_up, hit_mute, hit_down;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign adv     = (phase_r != PHASE_LAST) || !out_valid_r || out_ch.ready;
  assign step_en = (state_r == ST_RUN) && adv;
  assign key_en  = step_en && (phase_r == 2'd0);
  assign finish  = step_en && (phase_r == PHASE_LAST);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_up_code_r   <= RST_VOL_UP;
      mute_code_r     <= RST_MUTE;
      vol_down_code_r <= RST_VOL_DOWN;
      forward_code_r  <= RST_FORWARD;
      reverse_code_r  <= RST_REVERSE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_VOL_UP:   vol_up_code_r   <= cfg_ch.data;
        REG_MUTE:     mute_code_r     <= cfg_ch.data;
        REG_VOL_DOWN: vol_down_code_r <= cfg_ch.data;
        REG_FORWARD:  forward_code_r  <= cfg_ch.data;
        REG_REVERSE:  reverse_code_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  wksq_key u_key_up (
    .clk(clk), .rst_n(rst_n), .en(key_en), .level(up_r), .hit(hit_up)
  );
  wksq_key u_key_mute (
    .clk(clk), .rst_n(rst_n), .en(key_en), .level(mute_r), .hit(hit_mute)
  );
  wksq_key u_key_down (
    .clk(clk), .rst_n(rst_n), .en(key_en), .level(down_r), .hit(hit_down)
  );

  wksq_window #(.DEPTH(WINDOW_DEPTH)) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (step_en),
    .sample (pos_r),
    .agree  (agree)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        phase_nxt = '0;
        if (in_fire) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (phase_r == PHASE_LAST) begin
            state_nxt = ST_IDLE;
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    key_w_nxt = key_w_r;
    if (key_en) begin
      if (hit_down) begin
        key_w_nxt = vol_down_code_r;
      end else if (hit_mute) begin
        key_w_nxt = mute_code_r;
      end else if (hit_up) begin
        key_w_nxt = vol_up_code_r;
      end else begin
        key_w_nxt = CODE_NONE;
      end
    end
  end

  always_comb begin
    acc_nxt    = agree ? {{(ACC_W-POS_W){1'b0}}, pos_r} : acc_r;
    phist_nxt  = phist_r;
    turn_w_nxt = turn_w_r;
    if (phist_r[ACC_W-1:0] != acc_nxt) begin
      phist_nxt = {phist_r[ACC_W-1:0], acc_nxt};
      unique case (turn_decode(phist_nxt))
        TURN_FWD: turn_w_nxt = forward_code_r;
        TURN_REV: turn_w_nxt = reverse_code_r;
        default:  turn_w_nxt = CODE_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= POS_NONE;
      phist_r <= PHIST_RST;
    end else if (step_en) begin
      acc_r   <= acc_nxt;
      phist_r <= phist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      up_r     <= in_ch.vol_up_level;
      mute_r   <= in_ch.mute_level;
      down_r   <= in_ch.vol_down_level;
      pos_r    <= in_ch.wheel_position;
      turn_w_r <= CODE_NONE;
    end else if (step_en) begin
      turn_w_r <= turn_w_nxt;
    end
    key_w_r <= key_w_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_key_r  <= key_w_r;
      out_turn_r <= turn_w_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_code  = out_key_r;
  assign out_ch.turn_code = out_turn_r;

`ifndef SYNTH
  a_acc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r == POS_NONE) || (acc_r[ACC_W-1:POS_W] == '0))
    else $error("accepted position out of range");

  a_hist_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (phist_r[ACC_W-1:0] == acc_r))
    else $error("position history lost track of accepted position");

  a_out_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN && phase_r == PHASE_LAST))
    else $error("result raised outside last pass");
`endif

endmodule

`default_nettype wire

// File: rtl/wksq_key.sv
`timescale 1ns / 1ps
`default_nettype none

module wksq_key (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic level,
  output logic hit
);
  import wksq_pkg::*;

  logic [HIST_W-1:0] hist_r;
  logic [HIST_W-1:0] hist_nxt;
  logic [HIST_W-1:0] shifted;

  always_comb begin
    shifted  = {hist_r[HIST_W-2:0], level};
    hit      = ((shifted & KEY_MASK) == KEY_MATCH);
    hist_nxt = hit ? KEY_FULL : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (en) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wksq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wksq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [wksq_pkg::POS_W-1:0] in_val,
  input  logic                       in_match,
  output logic [wksq_pkg::POS_W-1:0] val,
  output logic                       out_match
);
  import wksq_pkg::*;

  logic [POS_W-1:0] val_r;

  // match of this entry with the one shifting into it, ANDed with the match from upstream
  assign out_match = in_match & (val_r == in_val);
  assign val       = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= in_val;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wksq_window.sv
`timescale 1ns / 1ps
`default_nettype none

module wksq_window #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [wksq_pkg::POS_W-1:0] sample,
  output logic                       agree
);
  import wksq_pkg::*;

  logic [POS_W-1:0] link_val [DEPTH+1];
  logic             link_match [DEPTH+1];

  assign link_val[0]   = sample;
  assign link_match[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    wksq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_val    (link_val[i]),
      .in_match  (link_match[i]),
      .val       (link_val[i+1]),
      .out_match (link_match[i+1])
    );
  end

  // last entry drops out on the shift, so its compare is ignored
  assign agree = link_match[DEPTH-1];

endmodule

`default_nettype wire

// File: verif/tb_wheel_and_key_scan_qualifier_unit.sv
`timescale 1ns / 1ps

module tb_wheel_and_key_scan_qualifier_unit;
  import wksq_pkg::*;

  localparam int unsigned RING_DEPTH      = 16;
  localparam int unsigned NUM_REGS        = 5;
  localparam int unsigned NUM_KEYS        = 3;
  localparam int unsigned KEY_UP          = 0;
  localparam int unsigned KEY_MUTE        = 1;
  localparam int unsigned KEY_DOWN        = 2;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned HOLD_AT         = 10;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PAUSE_AT        = 60;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned NUM_ROWS        = 25;

  localparam logic [POS_W-1:0] WHEEL_BOTH = 2'd3;

  typedef struct packed {
    logic             up;
    logic             mute;
    logic             down;
    logic [POS_W-1:0] wheel;
  } scan_tick_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [CODE_W-1:0] turn_code;
  } scan_codes_t;

  typedef struct {
    scan_tick_t  tick;
    bit          typed;
    scan_codes_t codes;
  } scan_row_t;

  logic clk;
  logic rst_n;

  wksq_in_if  in_ch ();
  wksq_out_if out_ch ();
  wksq_cfg_if cfg_ch ();

  wheel_and_key_scan_qualifier_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // tick bits: {vol_up, mute, vol_down, wheel[1:0]}
  scan_row_t scan_rows [NUM_ROWS] = '{
    '{5'b000_00, 1'b1, {CODE_NONE, CODE_NONE}},
    '{5'b111_00, 1'b1, {CODE_NONE, CODE_NONE}},
    '{5'b111_00, 1'b1, {CODE_NONE, CODE_NONE}},
    '{5'b111_00, 1'b1, {RST_VOL_DOWN, CODE_NONE}},
    '{5'b000_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b110_01, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b110_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b110_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_00, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b000_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b100_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b100_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b100_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b101_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b101_11, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b111_10, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b110_10, 1'b0, {CODE_NONE, CODE_NONE}},
    '{5'b110_10, 1'b0, {CODE_NONE, CODE_NONE}}
  };

  // scan qualifier state
  logic [HIST_W-1:0] key_hist [NUM_KEYS];
  logic [POS_W-1:0]  ring [RING_DEPTH];
  int unsigned       ring_ptr;
  logic [ACC_W-1:0]  held_pos;
  logic [HIST_W-1:0] step_hist;
  logic [CODE_W-1:0] code_reg [NUM_REGS];

  scan_codes_t awaited_codes [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_request;
  int unsigned hold_left;

  // random tick generator state
  bit               key_level [NUM_KEYS];
  int unsigned      key_run [NUM_KEYS];
  logic [POS_W-1:0] wheel_now;
  int unsigned      wheel_run;

  function automatic void clear_scan_state();
    code_reg[REG_VOL_UP]   = RST_VOL_UP;
    code_reg[REG_MUTE]     = RST_MUTE;
    code_reg[REG_VOL_DOWN] = RST_VOL_DOWN;
    code_reg[REG_FORWARD]  = RST_FORWARD;
    code_reg[REG_REVERSE]  = RST_REVERSE;
    foreach (ring[i]) ring[i] = '0;
    foreach (key_hist[k]) key_hist[k] = '0;
    ring_ptr  = 0;
    held_pos  = POS_NONE;
    step_hist = PHIST_RST;
  endfunction

  function automatic bit key_press(int unsigned k, logic level);
    key_hist[k] = {key_hist[k][HIST_W-2:0], level};
    if ((key_hist[k] & KEY_MASK) == KEY_MATCH) begin
      key_hist[k] = KEY_FULL;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void wheel_sample(logic [POS_W-1:0] pos, inout logic [CODE_W-1:0] turn);
    bit agree;
    agree = 1'b1;
    ring[ring_ptr] = pos;
    for (int i = 0; i + 1 < RING_DEPTH; i++) begin
      if (ring[i] != ring[i + 1]) agree = 1'b0;
    end
    if (agree) held_pos = ACC_W'(ring[RING_DEPTH - 1]);
    ring_ptr = (ring_ptr == RING_DEPTH - 1) ? 0 : ring_ptr + 1;
    if (step_hist[ACC_W-1:0] != held_pos) begin
      step_hist = {step_hist[ACC_W-1:0], held_pos};
      case (step_hist)
        8'h02, 8'h10, 8'h21: turn = code_reg[REG_FORWARD];
        8'h01, 8'h12, 8'h20: turn = code_reg[REG_REVERSE];
        default:             turn = CODE_NONE;
      endcase
    end
  endfunction

  // wheel sample is applied once after each key poll
  function automatic scan_codes_t predict_scan(scan_tick_t t);
    logic [CODE_W-1:0] key;
    logic [CODE_W-1:0] turn;
    key  = CODE_NONE;
    turn = CODE_NONE;
    if (key_press(KEY_UP, t.up)) key = code_reg[REG_VOL_UP];
    wheel_sample(t.wheel, turn);
    if (key_press(KEY_MUTE, t.mute)) key = code_reg[REG_MUTE];
    wheel_sample(t.wheel, turn);
    if (key_press(KEY_DOWN, t.down)) key = code_reg[REG_VOL_DOWN];
    wheel_sample(t.wheel, turn);
    return {key, turn};
  endfunction

  // held key levels and wheel positions with short glitches
  function automatic scan_tick_t next_random_tick();
    scan_tick_t t;
    logic       lv [NUM_KEYS];
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (key_run[k] == 0) begin
        key_level[k] = $urandom_range(1);
        key_run[k]   = $urandom_range(1, 9);
      end
      key_run[k]--;
      lv[k] = key_level[k] ^ ($urandom_range(99) < 8);
    end
    if (wheel_run == 0) begin
      wheel_now = ($urandom_range(9) == 0) ? WHEEL_BOTH : POS_W'($urandom_range(2));
      wheel_run = $urandom_range(2, 12);
    end
    wheel_run--;
    t.up    = lv[KEY_UP];
    t.mute  = lv[KEY_MUTE];
    t.down  = lv[KEY_DOWN];
    t.wheel = ($urandom_range(99) < 5) ? POS_W'($urandom) : wheel_now;
    return t;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_codes(logic [CODE_W-1:0] key, logic [CODE_W-1:0] turn);
    scan_codes_t want;
    if (awaited_codes.size() == 0) begin
      note_mismatch($sformatf("unexpected word: key_code %h turn_code %h", key, turn));
      return;
    end
    want = awaited_codes.pop_front();
    if (key !== want.key_code)
      note_mismatch($sformatf("key_code: expected %h actual %h", want.key_code, key));
    if (turn !== want.turn_code)
      note_mismatch($sformatf("turn_code: expected %h actual %h", want.turn_code, turn));
  endfunction

  // all drivers below enter and leave at a falling edge
  task automatic send_tick(scan_tick_t t, bit typed, scan_codes_t typed_codes);
    scan_codes_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.vol_up_level, in_ch.mute_level, in_ch.vol_down_level, in_ch.wheel_position} <= t;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = predict_scan(t);
    awaited_codes.push_back(typed ? typed_codes : want);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited_codes.size() != 0);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CODE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx < NUM_REGS) code_reg[idx] = value;
    @(negedge clk);
  endtask

  task automatic set_codes(logic [CODE_W-1:0] vals [NUM_REGS]);
    wait_drained();
    for (int r = 0; r < NUM_REGS; r++) write_reg(IDX_W'(r), vals[r]);
    // unmapped index, must be ignored
    write_reg(REG_REVERSE + IDX_W'($urandom_range(1, 3)), CODE_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, bit pressure);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (pressure && n == HOLD_AT) hold_request = 1'b1;
      if (pressure && n == PAUSE_AT) wait_drained();
      send_tick(next_random_tick(), 1'b0, {CODE_NONE, CODE_NONE});
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_codes(out_ch.key_code, out_ch.turn_code);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CODE_W-1:0] codes [NUM_REGS];
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.vol_up_level   = 1'b0;
    in_ch.mute_level     = 1'b0;
    in_ch.vol_down_level = 1'b0;
    in_ch.wheel_position = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_VOL_UP;
    cfg_ch.data          = CODE_NONE;
    mismatches           = 0;
    quiet_cycles         = 0;
    tx_idle_pct          = 0;
    rx_stall_pct         = 0;
    hold_request         = 1'b0;
    hold_left            = 0;
    wheel_now            = '0;
    wheel_run            = 0;
    foreach (key_run[k]) begin
      key_run[k]   = 0;
      key_level[k] = 1'b0;
    end
    clear_scan_state();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (scan_rows[i]) send_tick(scan_rows[i].tick, scan_rows[i].typed, scan_rows[i].codes);

    foreach (codes[r]) codes[r] = '1;
    set_codes(codes);
    run_phase(0, 0, 1'b1);

    foreach (codes[r]) codes[r] = CODE_NONE;
    set_codes(codes);
    run_phase(86, 0, 1'b0);

    foreach (codes[r]) codes[r] = CODE_W'($urandom);
    set_codes(codes);
    run_phase(0, 86, 1'b0);

    foreach (codes[r]) codes[r] = CODE_W'($urandom);
    set_codes(codes);
    run_phase(25, 25, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wksq_pkg.sv
rtl/wksq_if.sv
rtl/wksq_key.sv
rtl/wksq_cell.sv
rtl/wksq_window.sv
rtl/wheel_and_key_scan_qualifier_unit.sv
verif/tb_wheel_and_key_scan_qualifier_unit.sv
